/* src/lodd_pkg.sv */
// shared types and codes for the lock order deadlock detector
// no dependencies
package lodd_pkg;

    localparam int ID_W    = 5;
    localparam int NUM_IDS = 32;

    typedef enum logic [2:0] {
        ST_OK             = 3'd0,
        ST_DEADLOCK       = 3'd1,
        ST_MULTI_UNLOCK   = 3'd2,
        ST_INVALID_UNLOCK = 3'd3,
        ST_OVERFLOW       = 3'd4,
        ST_HALTED         = 3'd5
    } t_status;

    typedef enum logic {
        OP_ACQUIRE = 1'b0,
        OP_RELEASE = 1'b1
    } t_op;

endpackage

/* src/lock_order_deadlock_detector.sv */
// lock order deadlock detector: held stack, lock order matrix and iterative
// depth-first cycle search with at most one row read per cycle
// depends on lodd_pkg
//
// Each transfer on start/busy produces exactly one status on o_valid, one cycle
// long, which the receiver must take. A halted or rejected event and a release are
// answered from the idle state, an acquire that adds no edge from S_FIN. An acquire
// that adds a new edge runs a depth-first search over the order matrix, one matrix
// row read per step through a single read port. A release that leaves locks held
// stays busy through S_LDTOP and S_SETTOP after its status. After any error the
// block answers every event with halted until reset. No clearing pass is needed
// after reset.
module lock_order_deadlock_detector #(
    parameter int NUM_LOCKS   = 32,
    parameter int STACK_DEPTH = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic                      i_operation,
    input  logic [lodd_pkg::ID_W-1:0] i_lock_id,
    output logic                      o_valid,
    output lodd_pkg::t_status         o_status,
    output logic [lodd_pkg::ID_W-1:0] o_cycle_from,
    output logic [lodd_pkg::ID_W-1:0] o_cycle_to
);
    import lodd_pkg::*;

    localparam int LW  = $clog2(NUM_LOCKS);
    localparam int SPW = $clog2(NUM_LOCKS + 1);
    localparam int HIW = $clog2(STACK_DEPTH);
    localparam int HCW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_ACHK, S_ROOT, S_SCAN, S_POP, S_FIN, S_LDTOP, S_SETTOP
    } t_state;

    t_state              r_state;
    logic                r_halted;
    logic [HCW-1:0]      r_count;
    logic [LW-1:0]       r_top;
    logic [LW-1:0]       r_id;
    logic [LW-1:0]       r_here;
    logic [SPW-1:0]      r_sp;
    logic [NUM_LOCKS-1:0] r_visited;
    logic [NUM_LOCKS-1:0] r_finished;
    logic [NUM_LOCKS-1:0] r_rvld;
    logic                r_valid;
    t_status             r_status;
    logic [ID_W-1:0]     r_from;
    logic [ID_W-1:0]     r_to;

    logic [NUM_LOCKS-1:0] r_mat [NUM_LOCKS];
    logic [NUM_LOCKS-1:0] r_rowq;
    logic                 r_rowv;
    logic [LW-1:0]        r_held [STACK_DEPTH];
    logic [LW-1:0]        r_heldq;
    logic [LW-1:0]        r_sstk [NUM_LOCKS];
    logic [LW-1:0]        r_sstkq;

    logic [LW-1:0] w_idmod [NUM_IDS];
    logic [LW-1:0] id_m;

    logic                 mat_rd_en, mat_wr_en;
    logic [LW-1:0]        mat_rd_addr;
    logic [NUM_LOCKS-1:0] mat_wr_data;
    logic                 held_wr_en, held_rd_en;
    logic [HIW-1:0]       held_rd_addr;
    logic                 sstk_wr_en, sstk_rd_en;
    logic [LW-1:0]        sstk_rd_addr;

    logic [NUM_LOCKS-1:0] row_eff;
    logic [NUM_LOCKS-1:0] id_hot;
    logic [NUM_LOCKS-1:0] cand;
    logic                 root_found, cand_found;
    logic [LW-1:0]        root_idx, cand_idx;
    logic [SPW-1:0]       sp_m1;
    logic [HCW-1:0]       cnt_m1;

    function automatic logic [LW:0] f_low(input logic [NUM_LOCKS-1:0] v);
        logic [LW:0] res;
        res = '0;
        for (int i = NUM_LOCKS - 1; i >= 0; i--) begin
            if (v[i]) begin
                res = {1'b1, LW'(i)};
            end
        end
        return res;
    endfunction

    // lock id reduced modulo the number of locks
    for (genvar gi = 0; gi < NUM_IDS; gi++) begin : g_idmod
        assign w_idmod[gi] = LW'(gi % NUM_LOCKS);
    end

    assign id_m    = w_idmod[i_lock_id];
    assign busy    = (r_state != S_IDLE);
    assign row_eff = r_rowv ? r_rowq : '0;
    assign id_hot  = {{(NUM_LOCKS-1){1'b0}}, 1'b1} << r_id;
    assign cand    = row_eff & ~r_finished;
    assign sp_m1   = r_sp - SPW'(1);
    assign cnt_m1  = r_count - HCW'(1);
    assign {root_found, root_idx} = f_low(~r_visited);
    assign {cand_found, cand_idx} = f_low(cand);

    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_cycle_from = r_from;
    assign o_cycle_to   = r_to;

    always_comb begin
        mat_rd_en    = 1'b0;
        mat_rd_addr  = r_here;
        mat_wr_en    = 1'b0;
        mat_wr_data  = row_eff | id_hot;
        held_wr_en   = 1'b0;
        held_rd_en   = 1'b0;
        held_rd_addr = cnt_m1[HIW-1:0];
        sstk_wr_en   = 1'b0;
        sstk_rd_en   = 1'b0;
        sstk_rd_addr = sp_m1[LW-1:0];
        case (r_state)
            S_IDLE: begin
                mat_rd_en   = start;
                mat_rd_addr = r_top;
            end
            S_ACHK: begin
                mat_wr_en = ~|(row_eff & id_hot);
            end
            S_ROOT: begin
                mat_rd_en   = root_found;
                mat_rd_addr = root_idx;
            end
            S_SCAN: begin
                if (!cand_found) begin
                    sstk_rd_en = (r_sp != '0);
                end else if (!r_visited[cand_idx]) begin
                    sstk_wr_en  = 1'b1;
                    mat_rd_en   = 1'b1;
                    mat_rd_addr = cand_idx;
                end
            end
            S_POP: begin
                mat_rd_en   = 1'b1;
                mat_rd_addr = r_sstkq;
            end
            S_FIN: begin
                held_wr_en = (r_count != HCW'(STACK_DEPTH));
            end
            S_LDTOP: begin
                held_rd_en = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mat_wr_en) begin
            r_mat[r_top] <= mat_wr_data;
        end
        if (mat_rd_en) begin
            r_rowq <= r_mat[mat_rd_addr];
            r_rowv <= r_rvld[mat_rd_addr];
        end
        if (held_wr_en) begin
            r_held[r_count[HIW-1:0]] <= r_id;
        end
        if (held_rd_en) begin
            r_heldq <= r_held[held_rd_addr];
        end
        if (sstk_wr_en) begin
            r_sstk[r_sp[LW-1:0]] <= r_here;
        end
        if (sstk_rd_en) begin
            r_sstkq <= r_sstk[sstk_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_halted   <= 1'b0;
            r_count    <= '0;
            r_sp       <= '0;
            r_visited  <= '0;
            r_finished <= '0;
            r_rvld     <= '0;
            r_valid    <= 1'b0;
            r_status   <= ST_OK;
            r_from     <= '0;
            r_to       <= '0;
        end else begin
            r_valid <= 1'b0;
            r_from  <= '0;
            r_to    <= '0;
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_id <= id_m;
                        if (r_halted) begin
                            r_valid  <= 1'b1;
                            r_status <= ST_HALTED;
                        end else if (i_operation == OP_ACQUIRE) begin
                            if (r_count == '0 || r_top == id_m) begin
                                r_state <= S_FIN;
                            end else begin
                                r_state <= S_ACHK;
                            end
                        end else if (r_count == '0) begin
                            r_valid  <= 1'b1;
                            r_status <= ST_MULTI_UNLOCK;
                            r_halted <= 1'b1;
                        end else if (r_top != id_m) begin
                            r_valid  <= 1'b1;
                            r_status <= ST_INVALID_UNLOCK;
                            r_halted <= 1'b1;
                        end else begin
                            r_valid  <= 1'b1;
                            r_status <= ST_OK;
                            r_count  <= cnt_m1;
                            if (r_count != HCW'(1)) begin
                                r_state <= S_LDTOP;
                            end
                        end
                    end
                end
                S_ACHK: begin
                    if (|(row_eff & id_hot)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_rvld[r_top] <= 1'b1;
                        r_visited     <= '0;
                        r_finished    <= '0;
                        r_sp          <= '0;
                        r_state       <= S_ROOT;
                    end
                end
                S_ROOT: begin
                    if (root_found) begin
                        r_visited[root_idx] <= 1'b1;
                        r_here              <= root_idx;
                        r_state             <= S_SCAN;
                    end else begin
                        r_state <= S_FIN;
                    end
                end
                S_SCAN: begin
                    if (!cand_found) begin
                        r_finished[r_here] <= 1'b1;
                        if (r_sp == '0) begin
                            r_state <= S_ROOT;
                        end else begin
                            r_sp    <= sp_m1;
                            r_state <= S_POP;
                        end
                    end else if (r_visited[cand_idx]) begin
                        // back edge to a node still on the search path
                        r_valid  <= 1'b1;
                        r_status <= ST_DEADLOCK;
                        r_from   <= ID_W'(r_here);
                        r_to     <= ID_W'(cand_idx);
                        r_halted <= 1'b1;
                        r_state  <= S_IDLE;
                    end else begin
                        r_visited[cand_idx] <= 1'b1;
                        r_sp                <= r_sp + SPW'(1);
                        r_here              <= cand_idx;
                    end
                end
                S_POP: begin
                    r_here  <= r_sstkq;
                    r_state <= S_SCAN;
                end
                S_FIN: begin
                    r_valid <= 1'b1;
                    r_state <= S_IDLE;
                    if (r_count == HCW'(STACK_DEPTH)) begin
                        r_status <= ST_OVERFLOW;
                        r_halted <= 1'b1;
                    end else begin
                        r_status <= ST_OK;
                        r_count  <= r_count + HCW'(1);
                        r_top    <= r_id;
                    end
                end
                S_LDTOP: begin
                    r_state <= S_SETTOP;
                end
                S_SETTOP: begin
                    r_top   <= r_heldq;
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

`ifndef SYNTH
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    a_cycle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_DEADLOCK) |-> (o_cycle_from == '0 && o_cycle_to == '0))
        else $error("cycle fields set on a non-deadlock status");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= HCW'(STACK_DEPTH))
        else $error("held count beyond stack depth");

    a_accept_resp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (o_valid || busy))
        else $error("accepted event neither answered nor in progress");
`endif

endmodule

/* dv/tb_lock_order_deadlock_detector.sv */
// testbench for lock_order_deadlock_detector: well-formed lock traffic, then one fatal error
// and halted events, each status checked against a behavioral model of the detector
// depends on lodd_pkg and the detector rtl
module tb_lock_order_deadlock_detector;
    timeunit 1ns;
    timeprecision 1ps;
    import lodd_pkg::*;

    typedef logic [31:0] t_matrix [32];

    typedef struct {
        t_matrix    order;
        logic [4:0] held [16];
        int         held_cnt;
        bit         halted;
    } t_locks;

    typedef struct {
        t_status    status;
        logic [4:0] from_id;
        logic [4:0] to_id;
    } t_answer;

    logic       i_clk;
    logic       i_rst_n;
    logic       start;
    logic       busy;
    logic       i_operation;
    logic [4:0] i_lock_id;
    logic       o_valid;
    t_status    o_status;
    logic [4:0] o_cycle_from;
    logic [4:0] o_cycle_to;

    t_locks  lock_state;
    t_answer pending_status [$];
    int      error_cnt;
    int      stall_cnt;
    bit      calm;

    lock_order_deadlock_detector i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_lock_id   (i_lock_id),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_cycle_from(o_cycle_from),
        .o_cycle_to  (o_cycle_to)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic bit find_back_edge(input t_matrix m, output logic [4:0] f,
                                          output logic [4:0] t);
        logic [31:0] seen;
        logic [31:0] done;
        int          vnum [32];
        int          snode [33];
        int          snext [33];
        int          count;
        int          sp;
        int          here;
        int          there;
        bit          down;
        seen  = '0;
        done  = '0;
        count = 0;
        f     = '0;
        t     = '0;
        for (int root = 0; root < 32; root++) begin
            if (seen[root]) continue;
            seen[root] = 1'b1;
            vnum[root] = count++;
            snode[0] = root;
            snext[0] = 0;
            sp = 1;
            while (sp > 0) begin
                here = snode[sp-1];
                down = 1'b0;
                while (snext[sp-1] < 32) begin
                    there = snext[sp-1];
                    snext[sp-1]++;
                    if (!m[here][there]) continue;
                    if (!seen[there]) begin
                        seen[there] = 1'b1;
                        vnum[there] = count++;
                        snode[sp] = there;
                        snext[sp] = 0;
                        sp++;
                        down = 1'b1;
                        break;
                    end
                    if (vnum[here] < vnum[there]) continue;
                    if (!done[there]) begin
                        f = here[4:0];
                        t = there[4:0];
                        return 1'b1;
                    end
                end
                if (!down) begin
                    done[here] = 1'b1;
                    sp--;
                end
            end
        end
        return 1'b0;
    endfunction

    function automatic t_answer detector_step(inout t_locks s, input t_op op,
                                              input logic [4:0] id);
        t_answer    a;
        logic [4:0] prev;
        bit         dead;
        a.status  = ST_OK;
        a.from_id = '0;
        a.to_id   = '0;
        dead      = 1'b0;
        if (s.halted) begin
            a.status = ST_HALTED;
        end else if (op == OP_ACQUIRE) begin
            if (s.held_cnt > 0) begin
                prev = s.held[s.held_cnt-1];
                if (prev != id && !s.order[prev][id]) begin
                    s.order[prev][id] = 1'b1;
                    dead = find_back_edge(s.order, a.from_id, a.to_id);
                end
            end
            if (dead) begin
                a.status = ST_DEADLOCK;
                s.halted = 1'b1;
            end else if (s.held_cnt >= 16) begin
                a.status = ST_OVERFLOW;
                s.halted = 1'b1;
            end else begin
                s.held[s.held_cnt] = id;
                s.held_cnt++;
            end
        end else begin
            if (s.held_cnt == 0) begin
                a.status = ST_MULTI_UNLOCK;
                s.halted = 1'b1;
            end else if (s.held[s.held_cnt-1] != id) begin
                a.status = ST_INVALID_UNLOCK;
                s.halted = 1'b1;
            end else begin
                s.held_cnt--;
            end
        end
        return a;
    endfunction

    // start stays high between back-to-back transfers, lowered only on a gap
    task automatic send_event(input t_op op, input logic [4:0] id);
        if (!calm && $urandom_range(99) < 31) begin
            start <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge i_clk);
        end
        start       <= 1'b1;
        i_operation <= op;
        i_lock_id   <= id;
        do @(posedge i_clk); while (busy);
        pending_status.push_back(detector_step(lock_state, op, id));
    endtask

    task automatic release_all();
        while (lock_state.held_cnt > 0 && !lock_state.halted)
            send_event(OP_RELEASE, lock_state.held[lock_state.held_cnt-1]);
    endtask

    task automatic test_directed();
        send_event(OP_ACQUIRE, 5'd0);
        send_event(OP_ACQUIRE, 5'd31);
        send_event(OP_ACQUIRE, 5'd31);
        send_event(OP_RELEASE, 5'd31);
        send_event(OP_RELEASE, 5'd31);
        send_event(OP_RELEASE, 5'd0);
        for (int k = 0; k < 16; k++) send_event(OP_ACQUIRE, 5'(k + 10));
        release_all();
    endtask

    // acquires that the model says are safe, releases of the top lock
    task automatic test_ordered_traffic(input int n);
        t_locks     probe;
        t_answer    a;
        logic [4:0] id;
        bit         ok;
        for (int k = 0; k < n; k++) begin
            calm = (k >= 100 && k < 220);
            ok = 1'b0;
            if (lock_state.held_cnt < 16 &&
                (lock_state.held_cnt == 0 || $urandom_range(99) < 55)) begin
                for (int r = 0; r < 8 && !ok; r++) begin
                    id    = 5'($urandom_range(31));
                    probe = lock_state;
                    a     = detector_step(probe, OP_ACQUIRE, id);
                    ok    = (a.status == ST_OK);
                end
            end
            if (ok) send_event(OP_ACQUIRE, id);
            else if (lock_state.held_cnt > 0)
                send_event(OP_RELEASE, lock_state.held[lock_state.held_cnt-1]);
            else send_event(OP_ACQUIRE, 5'($urandom_range(31)));
        end
        calm = 1'b0;
    endtask

    task automatic test_fatal_error();
        logic [4:0] a_id;
        logic [4:0] b_id;
        logic [4:0] top;
        case ($urandom_range(3))
            0: begin
                a_id = 5'($urandom_range(31));
                b_id = a_id + 5'($urandom_range(31, 1));
                release_all();
                send_event(OP_ACQUIRE, a_id);
                send_event(OP_ACQUIRE, b_id);
                send_event(OP_RELEASE, b_id);
                send_event(OP_RELEASE, a_id);
                send_event(OP_ACQUIRE, b_id);
                send_event(OP_ACQUIRE, a_id);
            end
            1: begin
                while (lock_state.held_cnt < 16 && !lock_state.halted)
                    send_event(OP_ACQUIRE, 5'($urandom_range(31)));
                send_event(OP_ACQUIRE, 5'($urandom_range(31)));
            end
            2: begin
                release_all();
                send_event(OP_RELEASE, 5'($urandom_range(31)));
            end
            default: begin
                if (lock_state.held_cnt == 0) send_event(OP_ACQUIRE, 5'($urandom_range(31)));
                top = lock_state.held[lock_state.held_cnt-1];
                send_event(OP_RELEASE, top + 5'($urandom_range(31, 1)));
            end
        endcase
        for (int k = 0; k < 12; k++)
            send_event(t_op'($urandom_range(1)), 5'($urandom_range(31)));
    endtask

    always @(posedge i_clk) begin
        t_answer e;
        if (o_valid) begin
            if (pending_status.size() == 0) begin
                $error("status transfer with none expected: %0d", o_status);
                error_cnt++;
            end else begin
                e = pending_status.pop_front();
                if (o_status !== e.status) begin
                    $error("status expected %0d actual %0d", e.status, o_status);
                    error_cnt++;
                end
                if (o_cycle_from !== e.from_id) begin
                    $error("cycle_from expected %0d actual %0d", e.from_id, o_cycle_from);
                    error_cnt++;
                end
                if (o_cycle_to !== e.to_id) begin
                    $error("cycle_to expected %0d actual %0d", e.to_id, o_cycle_to);
                    error_cnt++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid || !i_rst_n) stall_cnt <= 0;
        else stall_cnt <= stall_cnt + 1;
        if (stall_cnt > 3000) begin
            $display("tb_lock_order_deadlock_detector: errors");
            $finish;
        end
    end

    initial begin
        error_cnt   = 0;
        stall_cnt   = 0;
        calm        = 1'b0;
        start       <= 1'b0;
        i_operation <= 1'b0;
        i_lock_id   <= '0;
        i_rst_n     <= 1'b0;
        lock_state.order    = '{default: '0};
        lock_state.held     = '{default: '0};
        lock_state.held_cnt = 0;
        lock_state.halted   = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_ordered_traffic(600);
        test_fatal_error();
        start <= 1'b0;
        while (pending_status.size() != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
        if (error_cnt == 0 && pending_status.size() == 0) begin
            $display("tb_lock_order_deadlock_detector: clean");
        end else begin
            $display("tb_lock_order_deadlock_detector: errors");
        end
        $finish;
    end
endmodule
